[rtl/core/spvg_pkg.sv]
package spvg_pkg;

  localparam int MAX_VERTICES       = 62;
  localparam int COORD_BITS         = 16;
  localparam int TRIG_FRACTION_BITS = 16;

  localparam int IN_BITS  = 120;
  localparam int OUT_BITS = 32;

  localparam int CORDIC_STEPS = 16;
  localparam int ITER_BITS    = $clog2(CORDIC_STEPS);

  localparam logic [16:0] FULL_TURN   = 17'd92160;
  localparam logic [22:0] CLOSE_LIMIT = 23'd90880;
  localparam longint      GAIN_Q24    = 64'sd10188014;
  localparam int          RATIO_FRAC  = 12;

  // turn angle into binary angle: acc * 2^21 / 45 = acc * 46603 + acc * 17 / 45
  localparam logic [15:0] BANG_INT    = 16'd46603;
  localparam logic [4:0]  BANG_REM    = 5'd17;
  localparam logic [22:0] RECIP_45    = 23'd5965233;
  localparam int          RECIP_SHIFT = 28;

  typedef enum logic [1:0] {
    OP_STEP    = 2'd0,
    OP_STAR    = 2'd1,
    OP_ELLIPSE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic step_take;
    logic angle_a;
    logic angle_b;
    logic angle_c;
    logic rot_init;
    logic rot_step;
    logic mul;
    logic rnd;
    logic ratio;
    logic emit_center;
    logic emit_vertex;
    logic emit_close;
  } cmd_t;

  typedef struct packed {
    logic in_skip;
    logic need_div;
    logic div_done;
    logic n_zero;
    logic last_index;
    logic closing;
    logic rot_last;
    logic out_free;
  } status_t;

  function automatic logic [29:0] atan_entry(input logic [ITER_BITS-1:0] i);
    logic [29:0] v;
    unique case (i)
      4'd0:  v = 30'd536870912;
      4'd1:  v = 30'd316933406;
      4'd2:  v = 30'd167458907;
      4'd3:  v = 30'd85004756;
      4'd4:  v = 30'd42667331;
      4'd5:  v = 30'd21354465;
      4'd6:  v = 30'd10679838;
      4'd7:  v = 30'd5340245;
      4'd8:  v = 30'd2670163;
      4'd9:  v = 30'd1335087;
      4'd10: v = 30'd667544;
      4'd11: v = 30'd333772;
      4'd12: v = 30'd166886;
      4'd13: v = 30'd83443;
      4'd14: v = 30'd41722;
      4'd15: v = 30'd20861;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] sat_coord(input logic signed [33:0] v, input int cb);
    logic signed [33:0] lo;
    logic signed [33:0] hi;
    lo = -(34'sd1 <<< (cb - 1));
    hi = (34'sd1 <<< (cb - 1)) - 34'sd1;
    if (v < lo) return lo[15:0];
    if (v > hi) return hi[15:0];
    return v[15:0];
  endfunction

endpackage

[rtl/core/spvg_div.sv]
module spvg_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [16:0] dividend,
  input  logic [5:0]  divisor,
  output logic [16:0] quotient,
  output logic        done
);

  logic [5:0]  rem;
  logic [16:0] quo;
  logic [5:0]  dvs;
  logic [4:0]  cnt;
  logic        busy;
  logic [6:0]  rem_sh;
  logic        fits;

  assign rem_sh   = {rem, quo[16]};
  assign fits     = rem_sh >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd16) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? 6'(rem_sh - {1'b0, dvs}) : rem_sh[5:0];
      quo <= {quo[15:0], fits};
    end
  end

endmodule

[rtl/core/spvg_datapath.sv]
module spvg_datapath #(
  parameter int MAX_VERTICES       = spvg_pkg::MAX_VERTICES,
  parameter int COORD_BITS         = spvg_pkg::COORD_BITS,
  parameter int TRIG_FRACTION_BITS = spvg_pkg::TRIG_FRACTION_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  spvg_pkg::cmd_t                cmd,
  output spvg_pkg::status_t             status,
  input  logic [spvg_pkg::IN_BITS-1:0]  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [spvg_pkg::OUT_BITS-1:0] out_data,
  output logic                          out_last
);

  localparam int T  = TRIG_FRACTION_BITS;
  localparam int XW = T + 3;
  localparam int PW = T + 19;
  localparam longint KQ = ((spvg_pkg::GAIN_Q24 * 2 >>> (24 - T)) + 1) >>> 1;
  localparam logic signed [32:0] QUARTER = 33'sd1 <<< 30;

  logic [1:0]  op;
  logic [5:0]  n;
  logic [16:0] step;
  logic [14:0] rs, rb;
  logic [15:0] cx, cy, qx, qy;
  logic [5:0]  idx;
  logic [16:0] acc;
  logic [32:0] p1;
  logic [21:0] tr;
  logic [16:0] qf;
  logic [31:0] bang;
  logic signed [XW-1:0] x, y;
  logic signed [32:0]   z;
  logic [spvg_pkg::ITER_BITS-1:0] it;
  logic flip;
  logic signed [PW-1:0] px, py;
  logic signed [18:0]   ox, oy;
  logic signed [35:0]   sx, sy;
  logic [15:0] first_x, first_y;
  logic [15:0] out_x, out_y;

  logic [1:0]  in_op;
  logic [5:0]  in_n, in_n_clamped;
  logic [16:0] quotient;
  logic        div_done;
  logic [16:0] step_red, acc_sum, acc_next;
  logic [44:0] recip_prod;
  logic signed [32:0] zb;
  logic signed [XW-1:0] dx, dy;
  logic signed [32:0]   at;
  logic signed [PW-1:0] pxr, pyr;
  logic signed [35:0]   sxr, syr;
  logic signed [23:0]   offx, offy;
  logic signed [33:0]   sumx, sumy;
  logic signed [XW-1:0] cx_trig, sy_trig;
  logic [14:0] radius;
  logic        closing;

  assign in_op        = in_data[1:0];
  assign in_n         = in_data[7:2];
  assign in_n_clamped = (32'(in_n) > MAX_VERTICES) ? 6'(MAX_VERTICES) : in_n;

  spvg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (17'(spvg_pkg::FULL_TURN + {12'd0, n[5:1]})),
    .divisor  (n),
    .quotient (quotient),
    .done     (div_done)
  );

  assign closing = (23'(step) * 23'(n)) > spvg_pkg::CLOSE_LIMIT;

  assign status.in_skip    = in_op == spvg_pkg::OP_NONE;
  assign status.need_div   = (op != spvg_pkg::OP_STEP) && (n != 6'd0);
  assign status.div_done   = div_done;
  assign status.n_zero     = n == 6'd0;
  assign status.last_index = ({1'b0, idx} + 7'd1) == {1'b0, n};
  assign status.closing    = closing;
  assign status.rot_last   = it == spvg_pkg::ITER_BITS'(spvg_pkg::CORDIC_STEPS - 1);
  assign status.out_free   = !out_valid || out_ready;

  assign step_red = (step >= spvg_pkg::FULL_TURN) ? 17'(step - spvg_pkg::FULL_TURN) : step;
  assign acc_sum  = 17'(acc + step_red);
  assign acc_next = ({1'b0, acc} + {1'b0, step_red} >= {1'b0, spvg_pkg::FULL_TURN})
                    ? 17'(acc_sum - spvg_pkg::FULL_TURN) : acc_sum;

  assign recip_prod = 45'(tr) * 45'(spvg_pkg::RECIP_45);
  assign zb         = $signed({bang[31], bang});

  assign dx = y >>> it;
  assign dy = x >>> it;
  assign at = $signed({3'b000, spvg_pkg::atan_entry(it)});

  assign cx_trig = flip ? -x : x;
  assign sy_trig = flip ? -y : y;
  assign radius  = idx[0] ? rs : rb;

  assign pxr = px + (PW'(1) <<< (T - 1));
  assign pyr = py + (PW'(1) <<< (T - 1));
  assign sxr = sx + 36'sd2048;
  assign syr = sy + 36'sd2048;

  assign offx = (op == spvg_pkg::OP_ELLIPSE) ? sxr[35:spvg_pkg::RATIO_FRAC] : 24'(ox);
  assign offy = (op == spvg_pkg::OP_ELLIPSE) ? syr[35:spvg_pkg::RATIO_FRAC] : 24'(oy);
  assign sumx = 34'($signed(cx)) + 34'(offx);
  assign sumy = 34'($signed(cy)) + 34'(offy);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= in_op;
      n    <= in_n_clamped;
      step <= (in_op == spvg_pkg::OP_STEP) ? in_data[24:8] : '0;
      rs   <= (in_op == spvg_pkg::OP_ELLIPSE) ? in_data[54:40] : in_data[39:25];
      rb   <= in_data[54:40];
      cx   <= in_data[70:55];
      cy   <= in_data[86:71];
      qx   <= in_data[102:87];
      qy   <= in_data[118:103];
      idx  <= '0;
      acc  <= '0;
    end
    if (cmd.step_take) step <= quotient;
    if (cmd.angle_a) begin
      p1 <= 33'(acc) * 33'(spvg_pkg::BANG_INT);
      tr <= 22'(acc) * 22'(spvg_pkg::BANG_REM);
    end
    if (cmd.angle_b) qf <= recip_prod[spvg_pkg::RECIP_SHIFT +: 17];
    if (cmd.angle_c) bang <= 32'(p1 + 33'(qf));
    if (cmd.rot_init) begin
      x  <= XW'(KQ);
      y  <= '0;
      it <= '0;
      if (zb > QUARTER) begin
        z <= zb - (QUARTER <<< 1);
        flip <= 1'b1;
      end else if (zb < -QUARTER) begin
        z <= zb + (QUARTER <<< 1);
        flip <= 1'b1;
      end else begin
        z <= zb;
        flip <= 1'b0;
      end
    end else if (cmd.rot_step) begin
      it <= it + 1'b1;
      if (z >= 0) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end
    end
    if (cmd.mul) begin
      px <= PW'($signed({1'b0, radius})) * PW'(cx_trig);
      py <= PW'($signed({1'b0, radius})) * PW'(sy_trig);
    end
    if (cmd.rnd) begin
      ox <= pxr[PW-1:T];
      oy <= pyr[PW-1:T];
    end
    if (cmd.ratio) begin
      sx <= 36'(ox) * $signed({20'd0, qx});
      sy <= 36'(oy) * $signed({20'd0, qy});
    end
    if (cmd.emit_center) begin
      out_x    <= spvg_pkg::sat_coord(34'($signed(cx)), COORD_BITS);
      out_y    <= spvg_pkg::sat_coord(34'($signed(cy)), COORD_BITS);
      out_last <= n == 6'd0;
    end
    if (cmd.emit_vertex) begin
      out_x    <= spvg_pkg::sat_coord(sumx, COORD_BITS);
      out_y    <= spvg_pkg::sat_coord(sumy, COORD_BITS);
      out_last <= !closing && status.last_index;
      if (idx == 6'd0) begin
        first_x <= spvg_pkg::sat_coord(sumx, COORD_BITS);
        first_y <= spvg_pkg::sat_coord(sumy, COORD_BITS);
      end
      idx <= idx + 6'd1;
      acc <= acc_next;
    end
    if (cmd.emit_close) begin
      out_x    <= first_x;
      out_y    <= first_y;
      out_last <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_center || cmd.emit_vertex || cmd.emit_close) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_data = {out_y, out_x};

endmodule

[rtl/core/spvg_ctrl.sv]
module spvg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  spvg_pkg::status_t status,
  output spvg_pkg::cmd_t    cmd
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_PREP   = 14'b00000000000010,
    S_DIV    = 14'b00000000000100,
    S_CENTER = 14'b00000000001000,
    S_ANG_A  = 14'b00000000010000,
    S_ANG_B  = 14'b00000000100000,
    S_ANG_C  = 14'b00000001000000,
    S_ROT0   = 14'b00000010000000,
    S_ROT    = 14'b00000100000000,
    S_MUL    = 14'b00001000000000,
    S_RND    = 14'b00010000000000,
    S_RATIO  = 14'b00100000000000,
    S_SUM    = 14'b01000000000000,
    S_CLOSE  = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !status.in_skip) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        if (status.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_CENTER;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.step_take = 1'b1;
          state_next    = S_CENTER;
        end
      end
      S_CENTER: begin
        if (status.out_free) begin
          cmd.emit_center = 1'b1;
          state_next      = status.n_zero ? S_IDLE : S_ANG_A;
        end
      end
      S_ANG_A: begin
        cmd.angle_a = 1'b1;
        state_next  = S_ANG_B;
      end
      S_ANG_B: begin
        cmd.angle_b = 1'b1;
        state_next  = S_ANG_C;
      end
      S_ANG_C: begin
        cmd.angle_c = 1'b1;
        state_next  = S_ROT0;
      end
      S_ROT0: begin
        cmd.rot_init = 1'b1;
        state_next   = S_ROT;
      end
      S_ROT: begin
        cmd.rot_step = 1'b1;
        if (status.rot_last) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_RND;
      end
      S_RND: begin
        cmd.rnd    = 1'b1;
        state_next = S_RATIO;
      end
      S_RATIO: begin
        cmd.ratio  = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        if (status.out_free) begin
          cmd.emit_vertex = 1'b1;
          if (!status.last_index)  state_next = S_ANG_A;
          else if (status.closing) state_next = S_CLOSE;
          else                     state_next = S_IDLE;
        end
      end
      S_CLOSE: begin
        if (status.out_free) begin
          cmd.emit_close = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[rtl/core/star_polygon_vertex_generator.sv]
// Star and polygon vertex generator. Each accepted word is one shape request; the
// block answers with the center, then one word per perimeter vertex, then a closing
// copy of the first vertex when the shape turns past 355 degrees; tlast marks the
// final word. Operation 3 is dropped without output. In star and ellipse modes a
// serial divider forms the angle step first. Each vertex then passes through the
// angle-conversion stages, the 16-step shared CORDIC rotator and the multiply
// stages. A new request is taken only after the last word of the shape is loaded.
module star_polygon_vertex_generator #(
  parameter int MAX_VERTICES       = spvg_pkg::MAX_VERTICES,
  parameter int COORD_BITS         = spvg_pkg::COORD_BITS,
  parameter int TRIG_FRACTION_BITS = spvg_pkg::TRIG_FRACTION_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // operation, vertex_count, angle_step, odd radius, even radius,
  // center_x, center_y, ratio_x, ratio_y
  input  logic [spvg_pkg::IN_BITS-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // vertex_x, vertex_y
  output logic [spvg_pkg::OUT_BITS-1:0] m_tdata,
  output logic                          m_tlast
);

  spvg_pkg::cmd_t    cmd;
  spvg_pkg::status_t status;

  spvg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  spvg_datapath #(
    .MAX_VERTICES       (MAX_VERTICES),
    .COORD_BITS         (COORD_BITS),
    .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

`ifndef ASSERT_OFF
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tdata[1:0] != spvg_pkg::OP_NONE) |=> !s_tready)
    else $error("request accepted but block stayed ready");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    ($rose(m_tvalid) && m_tlast) |-> s_tready)
    else $error("last word loaded while shape still in progress");

  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.emit_center, cmd.emit_vertex, cmd.emit_close, cmd.load}))
    else $error("conflicting output commands");
`endif

endmodule

[tb/spvg_checker.sv]
`timescale 1ns / 1ps
module spvg_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [119:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [31:0]  m_tdata,
  input  logic         m_tlast,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
  } vertex_t;

  vertex_t expected_vertices[$];

  localparam longint ATAN_TAB [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861};

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rshift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp16(longint v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  function automatic void expect_word(longint x, longint y, bit last);
    vertex_t w;
    w.x = x[15:0];
    w.y = y[15:0];
    w.last = last;
    expected_vertices.insert(expected_vertices.size(), w);
  endfunction

  task automatic rotate(input longint ang, output longint c, output longint s);
    longint bang, z, q, x, y, dx, dy;
    bit flip;
    bang = ((ang % 92160) << 32) / 92160;
    z = bang[31] ? bang - (64'sd1 << 32) : bang;
    q = 64'sd1 << 30;
    x = ((spvg_pkg::GAIN_Q24 * 2 >>> (24 - spvg_pkg::TRIG_FRACTION_BITS)) + 1) >>> 1;
    y = 0;
    flip = 0;
    if (z > q) begin
      z -= 2 * q;
      flip = 1;
    end else if (z < -q) begin
      z += 2 * q;
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic predict_shape(input logic [119:0] d);
    spvg_pkg::op_t op;
    longint n, step, rs, rb, cx, cy, qx, qy, acc, c, s, r, ox, oy, vx, vy, fx, fy;
    bit closing;
    op = spvg_pkg::op_t'(d[1:0]);
    n = d[7:2];
    step = d[24:8];
    rs = d[39:25];
    rb = d[54:40];
    cx = $signed(d[70:55]);
    cy = $signed(d[86:71]);
    qx = d[102:87];
    qy = d[118:103];
    if (op == spvg_pkg::OP_NONE) return;
    if (n > spvg_pkg::MAX_VERTICES) n = spvg_pkg::MAX_VERTICES;
    if (op != spvg_pkg::OP_STEP) step = (n == 0) ? 0 : (92160 + n / 2) / n;
    if (op == spvg_pkg::OP_ELLIPSE) rs = rb;
    closing = step * n > 90880;
    expect_word(cx, cy, n == 0);
    acc = 0;
    fx = 0;
    fy = 0;
    for (longint i = 0; i < n; i++) begin
      rotate(acc, c, s);
      r = i[0] ? rs : rb;
      ox = rshift(r * c, spvg_pkg::TRIG_FRACTION_BITS);
      oy = rshift(r * s, spvg_pkg::TRIG_FRACTION_BITS);
      if (op == spvg_pkg::OP_ELLIPSE) begin
        ox = rshift(ox * qx, spvg_pkg::RATIO_FRAC);
        oy = rshift(oy * qy, spvg_pkg::RATIO_FRAC);
      end
      vx = clamp16(cx + ox);
      vy = clamp16(cy + oy);
      if (i == 0) begin
        fx = vx;
        fy = vy;
      end
      expect_word(vx, vy, !closing && i + 1 == n);
      acc = (acc + step % 92160) % 92160;
    end
    if (closing) expect_word(fx, fy, 1'b1);
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    vertex_t e;
    if (!rst) begin
      if (s_tvalid && s_tready) predict_shape(s_tdata);
      if (m_tvalid && m_tready) begin
        if (expected_vertices.size() == 0) begin
          $error("unexpected word x=%h y=%h", m_tdata[15:0], m_tdata[31:16]);
          fail_count++;
        end else begin
          e = expected_vertices.pop_front();
          if (m_tdata[15:0] !== e.x) begin
            $error("vertex_x expected %h actual %h", e.x, m_tdata[15:0]);
            fail_count++;
          end
          if (m_tdata[31:16] !== e.y) begin
            $error("vertex_y expected %h actual %h", e.y, m_tdata[31:16]);
            fail_count++;
          end
          if (m_tlast !== e.last) begin
            $error("last_vertex expected %b actual %b", e.last, m_tlast);
            fail_count++;
          end
        end
      end
      pending = expected_vertices.size();
    end
  end
endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [119:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [31:0]  m_tdata;
  logic         m_tlast;
  int           fail_count;
  int           pending;
  bit           hold_sink;

  star_polygon_vertex_generator i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  spvg_checker i_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [119:0] pack_shape(
      spvg_pkg::op_t op, logic [5:0] n, logic [16:0] st, logic [14:0] rs, logic [14:0] rb,
      logic [15:0] cx, logic [15:0] cy, logic [15:0] qx, logic [15:0] qy);
    return {1'b0, qy, qx, cy, cx, rb, rs, st, n, op};
  endfunction

  task automatic send_shape(input logic [119:0] d);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    while (!s_tready) @(negedge clk);
    @(negedge clk);
  endtask

  function automatic logic [119:0] random_shape();
    spvg_pkg::op_t op;
    logic [5:0] n;
    int p;
    p = $urandom_range(0, 99);
    if (p < 35) op = spvg_pkg::OP_STEP;
    else if (p < 65) op = spvg_pkg::OP_STAR;
    else if (p < 95) op = spvg_pkg::OP_ELLIPSE;
    else op = spvg_pkg::OP_NONE;
    p = $urandom_range(0, 99);
    if (p < 80) n = 6'($urandom_range(0, 8));
    else if (p < 95) n = 6'($urandom_range(9, 63));
    else n = 6'd63;
    return pack_shape(op, n, 17'($urandom_range(0, 131071)), 15'($urandom), 15'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
        m_tready <= 1'b0;
        repeat (gap_len()) @(negedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 99) < 76);
      end
    end
  end

  initial begin
    #200000000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    hold_sink = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    send_shape(pack_shape(spvg_pkg::OP_STEP, 6'd0, 17'd0, 15'd0, 15'd0,
                          16'h0000, 16'h0000, 16'd0, 16'd0));
    send_shape(pack_shape(spvg_pkg::OP_STEP, 6'd4, 17'd23040, 15'h7fff, 15'h7fff,
                          16'h7fff, 16'h8000, 16'hffff, 16'hffff));
    send_shape(pack_shape(spvg_pkg::OP_STEP, 6'd63, 17'h1ffff, 15'd100, 15'd200,
                          16'h0000, 16'h0000, 16'd0, 16'd0));
    send_shape(pack_shape(spvg_pkg::OP_STEP, 6'd3, 17'd30720, 15'd160, 15'd320,
                          16'h8000, 16'h7fff, 16'd0, 16'd0));
    send_shape(pack_shape(spvg_pkg::OP_STEP, 6'd2, 17'd92159, 15'd50, 15'd50,
                          16'h0100, 16'h0100, 16'd0, 16'd0));
    send_shape(pack_shape(spvg_pkg::OP_STAR, 6'd5, 17'd0, 15'd100, 15'h7fff,
                          16'h1000, 16'hf000, 16'd0, 16'd0));
    send_shape(pack_shape(spvg_pkg::OP_STAR, 6'd0, 17'd0, 15'd1, 15'd1,
                          16'h1234, 16'h4321, 16'd0, 16'd0));
    send_shape(pack_shape(spvg_pkg::OP_STAR, 6'd1, 17'd0, 15'd0, 15'h7fff,
                          16'h8000, 16'h8000, 16'd0, 16'd0));
    send_shape(pack_shape(spvg_pkg::OP_ELLIPSE, 6'd6, 17'h1ffff, 15'h7fff, 15'h7fff,
                          16'h0000, 16'h0000, 16'hffff, 16'h0000));
    send_shape(pack_shape(spvg_pkg::OP_ELLIPSE, 6'd8, 17'd0, 15'd0, 15'd800,
                          16'hffff, 16'h0001, 16'h1000, 16'h0800));
    send_shape(pack_shape(spvg_pkg::OP_NONE, 6'd7, 17'd100, 15'd5, 15'd5,
                          16'd0, 16'd0, 16'd0, 16'd0));
    send_shape(pack_shape(spvg_pkg::OP_STEP, 6'd62, 17'd1000, 15'h5555, 15'h2aaa,
                          16'h5555, 16'haaaa, 16'h5555, 16'haaaa));
    hold_sink = 1'b1;
    fork
      begin
        repeat (1500) @(posedge clk);
        hold_sink = 1'b0;
      end
      for (int k = 0; k < 4; k++) send_shape(random_shape());
    join
    for (int k = 0; k < 414; k++) send_shape(random_shape());
    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (2000) @(posedge clk);
    if (fail_count == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule
